@@ hdl/lsos_pkg.sv @@
// package: widths, reset values, register indexes and decision constants
package lsos_pkg;

    localparam int unsigned SECTORS_DEF       = 15;
    localparam int unsigned SECTOR_SIZE_DEF   = 50;
    localparam int unsigned MAX_SAMPLES_DEF   = 1024;
    localparam int unsigned BACKOFF_SCANS_DEF = 5;

    localparam int DIST_W     = 16;
    localparam int NODE_W     = 4;
    localparam int FIRST_W    = 10;
    localparam int MAG_W      = 7;
    localparam int SPEED_W    = 10;
    localparam int ANGLE_W    = 8;
    localparam int CMD_W      = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [FIRST_W-1:0] FIRST_INDEX_RST     = FIRST_W'(44);
    localparam logic [DIST_W-1:0]  INVALID_LIMIT_RST   = DIST_W'(20);
    localparam logic [DIST_W-1:0]  FAR_VALUE_RST       = DIST_W'(5600);
    localparam logic [DIST_W-1:0]  TURN_LIMIT_RST      = DIST_W'(600);
    localparam logic [DIST_W-1:0]  REVERSE_LIMIT_RST   = DIST_W'(250);
    localparam logic [MAG_W-1:0]   STEER_MAGNITUDE_RST = MAG_W'(30);
    localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST     = SPEED_W'(280);
    localparam logic [NODE_W-1:0]  RANGE_NODE_RST      = NODE_W'(2);

    localparam logic [MAG_W-1:0]   MAG_MAX   = MAG_W'(90);
    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(1000);

    localparam int DEC_FIRST = 3;
    localparam int DEC_LAST  = 11;
    localparam int DEC_SPLIT = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FIRST_INDEX,
        CFG_INVALID_LIMIT,
        CFG_FAR_VALUE,
        CFG_TURN_LIMIT,
        CFG_REVERSE_LIMIT,
        CFG_STEER_MAGNITUDE,
        CFG_DRIVE_SPEED,
        CFG_RANGE_NODE
    } t_cfg_idx;

endpackage

@@ hdl/lsos_smp_if.sv @@
// interface: range sample channel
interface lsos_smp_if import lsos_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [NODE_W-1:0] source_node;
    logic              scan_last;

    modport source (output valid, distance, source_node, scan_last, input ready);
    modport sink   (input valid, distance, source_node, scan_last, output ready);
endinterface

@@ hdl/lsos_res_if.sv @@
// interface: steering command channel
interface lsos_res_if import lsos_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] steer_angle;
    logic signed [CMD_W-1:0]   drive_command;
    logic                      reversing;

    modport source (output valid, steer_angle, drive_command, reversing, input ready);
    modport sink   (input valid, steer_angle, drive_command, reversing, output ready);
endinterface

@@ hdl/lidar_sector_obstacle_steer_top.sv @@
// top level: lidar sector minimum tracking and steering decision
// path: the last sample of a scan goes through the input register, the decision register and then the output register
// throughput: one sample per cycle; the input stalls only while a decided command
//   waits in the pipe and the output register still holds an untaken command
// reset: synchronous active low; registers return to defaults, sample index and
//   backoff count clear, sector minima reload at the first sample of each scan
module lidar_sector_obstacle_steer_top import lsos_pkg::*; #(
    parameter int unsigned SECTORS       = SECTORS_DEF,
    parameter int unsigned SECTOR_SIZE   = SECTOR_SIZE_DEF,
    parameter int unsigned MAX_SAMPLES   = MAX_SAMPLES_DEF,
    parameter int unsigned BACKOFF_SCANS = BACKOFF_SCANS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lsos_smp_if.sink              i_smp,
    lsos_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SEC_W  = $clog2(MAX_SAMPLES / SECTOR_SIZE + 1);
    localparam int OFF_W  = $clog2(SECTOR_SIZE + 1);
    localparam int SKIP_W = $clog2(BACKOFF_SCANS + 2);
    localparam int CMP_W  = (IDX_W > FIRST_W) ? IDX_W : FIRST_W;

    // configuration
    logic [FIRST_W-1:0] r_first;
    logic [DIST_W-1:0]  r_invalid;
    logic [DIST_W-1:0]  r_far;
    logic [DIST_W-1:0]  r_turn;
    logic [DIST_W-1:0]  r_rev_lim;
    logic [MAG_W-1:0]   r_steer;
    logic [SPEED_W-1:0] r_drive;
    logic [NODE_W-1:0]  r_node_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= FIRST_INDEX_RST;
            r_invalid  <= INVALID_LIMIT_RST;
            r_far      <= FAR_VALUE_RST;
            r_turn     <= TURN_LIMIT_RST;
            r_rev_lim  <= REVERSE_LIMIT_RST;
            r_steer    <= STEER_MAGNITUDE_RST;
            r_drive    <= DRIVE_SPEED_RST;
            r_node_sel <= RANGE_NODE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_INDEX:     r_first    <= i_cfg_data[FIRST_W-1:0];
                CFG_INVALID_LIMIT:   r_invalid  <= i_cfg_data[DIST_W-1:0];
                CFG_FAR_VALUE:       r_far      <= i_cfg_data[DIST_W-1:0];
                CFG_TURN_LIMIT:      r_turn     <= i_cfg_data[DIST_W-1:0];
                CFG_REVERSE_LIMIT:   r_rev_lim  <= i_cfg_data[DIST_W-1:0];
                CFG_STEER_MAGNITUDE: r_steer    <= i_cfg_data[MAG_W-1:0];
                CFG_DRIVE_SPEED:     r_drive    <= i_cfg_data[SPEED_W-1:0];
                CFG_RANGE_NODE:      r_node_sel <= i_cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline registers and state
    logic              r_in_v;
    logic [DIST_W-1:0] r_dist;
    logic [NODE_W-1:0] r_node;
    logic              r_last;
    logic [IDX_W-1:0]  r_idx;
    logic [SEC_W-1:0]  r_sec;
    logic [OFF_W-1:0]  r_off;
    logic [SKIP_W-1:0] r_skip;
    logic              r_skipped;
    logic [DIST_W-1:0] r_min [SECTORS];
    logic              r_d_v;
    logic              r_o_v;
    logic signed [ANGLE_W-1:0] r_angle;
    logic signed [CMD_W-1:0]   r_cmd;
    logic                      r_rev;

    logic advance;
    logic s1_fire;
    logic s2_fire;

    // stage 1 signals
    logic              scan_start;
    logic              cur_skipped;
    logic              in_range;
    logic              use_smp;
    logic [DIST_W-1:0] d_eff;
    logic [DIST_W-1:0] n_min [SECTORS];
    logic              decide;
    logic [SKIP_W-1:0] e_skip;
    logic [SKIP_W-1:0] n_skip;
    logic [IDX_W-1:0]  n_idx;
    logic [SEC_W-1:0]  n_sec;
    logic [OFF_W-1:0]  n_off;

    // stage 2 signals
    logic                      hit;
    logic                      left;
    logic                      rev;
    logic [MAG_W-1:0]          mag;
    logic [SPEED_W-1:0]        spd;
    logic signed [ANGLE_W-1:0] pos_angle;
    logic signed [ANGLE_W-1:0] n_angle;
    logic signed [CMD_W-1:0]   n_cmd;

    assign advance     = !(r_d_v && r_o_v && !o_res.ready);
    assign i_smp.ready = advance;
    assign s1_fire     = r_in_v && advance;
    assign s2_fire     = r_d_v && advance;

    // stage 1: sector minimum update
    assign e_skip      = (s2_fire && rev) ? SKIP_W'(BACKOFF_SCANS + 1) : r_skip;
    assign scan_start  = (r_idx == '0);
    assign cur_skipped = scan_start ? (e_skip != '0) : r_skipped;
    assign in_range    = (r_idx < IDX_W'(MAX_SAMPLES));
    assign use_smp     = in_range && (CMP_W'(r_idx) >= CMP_W'(r_first))
                         && (int'(r_sec) < int'(SECTORS));
    assign d_eff       = (r_dist <= r_invalid) ? r_far : r_dist;
    assign decide      = r_last && !cur_skipped && (r_node == r_node_sel);

    always_comb begin
        logic [DIST_W-1:0] base;
        for (int s = 0; s < int'(SECTORS); s++) begin
            base     = scan_start ? r_far : r_min[s];
            n_min[s] = (use_smp && (int'(r_sec) == s) && (base > d_eff)) ? d_eff : base;
        end
    end

    always_comb begin
        n_skip = e_skip;
        if (s1_fire && r_last && cur_skipped && (e_skip != '0)) begin
            n_skip = e_skip - SKIP_W'(1);
        end
    end

    always_comb begin
        n_idx = r_idx;
        n_sec = r_sec;
        n_off = r_off;
        if (r_last) begin
            n_idx = '0;
            n_sec = '0;
            n_off = '0;
        end else if (in_range) begin
            n_idx = r_idx + IDX_W'(1);
            if (r_off == OFF_W'(SECTOR_SIZE - 1)) begin
                n_off = '0;
                n_sec = r_sec + SEC_W'(1);
            end else begin
                n_off = r_off + OFF_W'(1);
            end
        end
    end

    // stage 2: steering decision
    always_comb begin
        hit  = 1'b0;
        left = 1'b0;
        rev  = 1'b0;
        for (int k = DEC_FIRST; k <= DEC_LAST; k++) begin
            if ((r_min[k-1] > r_min[k]) && (r_min[k] < r_turn)) begin
                hit  = 1'b1;
                left = (k < DEC_SPLIT);
            end
            if (r_min[k] <= r_rev_lim) begin
                rev = 1'b1;
            end
        end
    end

    assign mag       = (r_steer > MAG_MAX) ? MAG_MAX : r_steer;
    assign spd       = (r_drive > SPEED_MAX) ? SPEED_MAX : r_drive;
    assign pos_angle = ANGLE_W'(mag);
    assign n_angle   = !hit ? '0 : ((left ^ rev) ? pos_angle : -pos_angle);
    assign n_cmd     = rev ? CMD_W'(spd) : -CMD_W'(spd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_idx     <= '0;
            r_sec     <= '0;
            r_off     <= '0;
            r_skip    <= '0;
            r_skipped <= 1'b0;
            r_d_v     <= 1'b0;
            r_o_v     <= 1'b0;
        end else begin
            if (advance) begin
                r_in_v <= i_smp.valid;
                r_d_v  <= s1_fire && decide;
            end
            if (s1_fire) begin
                r_idx <= n_idx;
                r_sec <= n_sec;
                r_off <= n_off;
                if (scan_start) begin
                    r_skipped <= (e_skip != '0);
                end
            end
            r_skip <= n_skip;
            if (s2_fire) begin
                r_o_v <= 1'b1;
            end else if (o_res.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_dist <= i_smp.distance;
            r_node <= i_smp.source_node;
            r_last <= i_smp.scan_last;
        end
        if (s1_fire) begin
            for (int s = 0; s < int'(SECTORS); s++) begin
                r_min[s] <= n_min[s];
            end
        end
        if (s2_fire) begin
            r_angle <= n_angle;
            r_cmd   <= n_cmd;
            r_rev   <= rev;
        end
    end

    assign o_res.valid         = r_o_v;
    assign o_res.steer_angle   = r_angle;
    assign o_res.drive_command = r_cmd;
    assign o_res.reversing     = r_rev;

    // checks
    a_skip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= SKIP_W'(BACKOFF_SCANS + 1))
        else $error("backoff count out of range");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(MAX_SAMPLES))
        else $error("sample index beyond saturation");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> (o_res.valid && !o_res.ready && r_d_v))
        else $error("input stalled without a blocked command");

    a_rev_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && rev) |=> (r_skip != '0) && r_o_v)
        else $error("reverse without backoff");

endmodule

@@ tb/lidar_sector_obstacle_steer_top_test.sv @@
`timescale 1ns / 1ps
// testbench: lidar sector steering, directed scan table then random scans checked by a predictor
module lidar_sector_obstacle_steer_top_test;
    import lsos_pkg::*;

    localparam int unsigned SECT_SLOTS    = 24;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RANDOM_ITEMS  = 150;
    localparam int unsigned PHASE_ITEMS   = 80;
    localparam int unsigned MAX_PHASES    = 8;
    localparam int unsigned PRESSURE_SCANS = 40;
    localparam int unsigned SHOWN_ERRORS  = 10;
    localparam int unsigned DIR_ROWS      = 24;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [CMD_W-1:0]   drive;
        logic                      rev;
    } steer_cmd_t;

    typedef struct {
        int unsigned       rep;
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] node;
        bit                last;
        bit                typed_in;
        bit                has_cmd;
        steer_cmd_t        cmd;
    } scan_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lsos_smp_if smp_ch ();
    lsos_res_if res_ch ();

    lidar_sector_obstacle_steer_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the registers and the scan state
    logic [FIRST_W-1:0] cur_first;
    logic [DIST_W-1:0]  cur_invalid;
    logic [DIST_W-1:0]  cur_far;
    logic [DIST_W-1:0]  cur_turn;
    logic [DIST_W-1:0]  cur_reverse;
    logic [MAG_W-1:0]   cur_mag;
    logic [SPEED_W-1:0] cur_speed;
    logic [NODE_W-1:0]  cur_node;
    logic [DIST_W-1:0]  sect_min [SECTORS_DEF];
    int unsigned        scan_pos;
    int unsigned        backoff_left;
    bit                 scan_ignored;

    steer_cmd_t  cmd_expected [$];
    scan_row_t   scan_rows [DIR_ROWS];
    int unsigned n_samples;
    int unsigned n_scans;
    int unsigned n_cmds_pred;
    int unsigned n_cmds_seen;
    int unsigned n_reverse;
    int unsigned n_mismatch;
    int unsigned n_cfg_writes;
    int unsigned cycle_count;
    bit          burst_mode;
    bit          hold_out_req;
    bit          hold_active;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit predict_steer(input logic [DIST_W-1:0] dval,
                                         input logic [NODE_W-1:0] node,
                                         input logic last, output steer_cmd_t cmd);
        int unsigned       sec;
        int                s;
        int                k;
        int                mag;
        int                speed;
        int                angle;
        bit                rev;
        logic [DIST_W-1:0] d;
        cmd = '0;
        d = dval;
        if (scan_pos == 0) begin
            for (s = 0; s < SECTORS_DEF; s++) sect_min[s] = cur_far;
            scan_ignored = (backoff_left != 0);
        end
        if (scan_pos < MAX_SAMPLES_DEF) begin
            if (scan_pos >= cur_first) begin
                sec = scan_pos / SECTOR_SIZE_DEF;
                if (d <= cur_invalid) d = cur_far;
                if (sec < SECTORS_DEF && sect_min[sec] > d) sect_min[sec] = d;
            end
            scan_pos++;
        end
        if (!last) return 1'b0;
        scan_pos = 0;
        if (scan_ignored) begin
            if (backoff_left > 0) backoff_left--;
            return 1'b0;
        end
        if (node != cur_node) return 1'b0;
        mag = (cur_mag > MAG_MAX) ? int'(MAG_MAX) : int'(cur_mag);
        speed = (cur_speed > SPEED_MAX) ? int'(SPEED_MAX) : int'(cur_speed);
        angle = 0;
        rev = 1'b0;
        for (k = DEC_FIRST; k <= DEC_LAST; k++) begin
            if (sect_min[k-1] > sect_min[k] && sect_min[k] < cur_turn)
                angle = (k < DEC_SPLIT) ? mag : -mag;
            if (sect_min[k] <= cur_reverse) rev = 1'b1;
        end
        if (rev) begin
            angle = -angle;
            backoff_left = BACKOFF_SCANS_DEF + 1;
        end else begin
            speed = -speed;
        end
        cmd.angle = ANGLE_W'(angle);
        cmd.drive = CMD_W'(speed);
        cmd.rev = rev;
        return 1'b1;
    endfunction

    function automatic logic [DIST_W-1:0] jitter_around(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return DIST_W'(v);
    endfunction

    function automatic int unsigned smp_gap();
        int unsigned r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic note_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= SHOWN_ERRORS) $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FIRST_INDEX:     cur_first = data[FIRST_W-1:0];
            CFG_INVALID_LIMIT:   cur_invalid = data[DIST_W-1:0];
            CFG_FAR_VALUE:       cur_far = data[DIST_W-1:0];
            CFG_TURN_LIMIT:      cur_turn = data[DIST_W-1:0];
            CFG_REVERSE_LIMIT:   cur_reverse = data[DIST_W-1:0];
            CFG_STEER_MAGNITUDE: cur_mag = data[MAG_W-1:0];
            CFG_DRIVE_SPEED:     cur_speed = data[SPEED_W-1:0];
            CFG_RANGE_NODE:      cur_node = data[NODE_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic config_random(input bit write_all);
        int unsigned           i;
        int unsigned           w;
        int unsigned           lo_t;
        int unsigned           hi_t;
        int unsigned           val;
        int unsigned           r;
        logic [CFG_DATA_W-1:0] data;
        t_cfg_idx              idx;
        for (i = 0; i <= int'(CFG_RANGE_NODE); i++) begin
            idx = t_cfg_idx'(i);
            case (idx)
                CFG_FIRST_INDEX:     begin w = FIRST_W; lo_t = 0;   hi_t = 200;  end
                CFG_INVALID_LIMIT:   begin w = DIST_W;  lo_t = 0;   hi_t = 100;  end
                CFG_FAR_VALUE:       begin w = DIST_W;  lo_t = 300; hi_t = 8000; end
                CFG_TURN_LIMIT:      begin w = DIST_W;  lo_t = 100; hi_t = 3000; end
                CFG_REVERSE_LIMIT:   begin w = DIST_W;  lo_t = 0;   hi_t = 800;  end
                CFG_STEER_MAGNITUDE: begin w = MAG_W;   lo_t = 0;   hi_t = 127;  end
                CFG_DRIVE_SPEED:     begin w = SPEED_W; lo_t = 0;   hi_t = 1023; end
                default:             begin w = NODE_W;  lo_t = 0;   hi_t = 15;   end
            endcase
            r = $urandom_range(0, 9);
            if (r < 2) val = 0;
            else if (r < 4) val = (1 << w) - 1;
            else val = $urandom_range(lo_t, hi_t);
            data = CFG_DATA_W'(val);
            // junk above the register width must be dropped
            if (w < CFG_DATA_W && $urandom_range(0, 1) == 1)
                data = data | (CFG_DATA_W'($urandom) << w);
            if (write_all || $urandom_range(0, 1) == 1) write_reg(idx, data);
        end
    endtask

    task automatic send_sample(input logic [DIST_W-1:0] dval, input logic [NODE_W-1:0] node,
                               input logic last, input bit typed_in, input bit typed_has,
                               input steer_cmd_t typed_cmd);
        int unsigned gap;
        bit          has_p;
        steer_cmd_t  cmd_p;
        gap = smp_gap();
        if (gap != 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.distance <= dval;
        smp_ch.source_node <= node;
        smp_ch.scan_last <= last;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        n_samples++;
        if (last) n_scans++;
        has_p = predict_steer(dval, node, last, cmd_p);
        if (typed_in ? typed_has : has_p) begin
            cmd_expected.push_back(typed_in ? typed_cmd : cmd_p);
            n_cmds_pred++;
        end
    endtask

    task automatic send_scan(input int unsigned len);
        logic [DIST_W-1:0] lvl [SECT_SLOTS];
        logic [DIST_W-1:0] d;
        logic [NODE_W-1:0] nd;
        steer_cmd_t        none;
        int unsigned       r;
        int unsigned       i;
        none = '0;
        for (i = 0; i < SECT_SLOTS; i++) begin
            r = $urandom_range(0, 9);
            if (r < 3) lvl[i] = jitter_around(int'(cur_turn), 200);
            else if (r < 5) lvl[i] = jitter_around(int'(cur_reverse), 100);
            else if (r < 7) lvl[i] = jitter_around(int'(cur_far), 300);
            else lvl[i] = DIST_W'($urandom);
        end
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) d = DIST_W'($urandom_range(0, cur_invalid));
            else if (r < 12) d = DIST_W'($urandom);
            else d = jitter_around(int'(lvl[i / SECTOR_SIZE_DEF]), 40);
            r = $urandom_range(0, 99);
            if (r < ((i == len - 1) ? 85 : 75)) nd = cur_node;
            else nd = NODE_W'($urandom);
            send_sample(d, nd, i == len - 1, 1'b0, 1'b0, none);
        end
    endtask

    task automatic wait_drained();
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d commands outstanding",
                 cycle_count, cmd_expected.size());
        $display("FAIL");
        $finish;
    end

    // receiver: random ready with short and long stalls, one long hold on request
    initial begin
        int unsigned run;
        int unsigned hold_cnt;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_out_req) begin
                res_ch.ready <= 1'b0;
                hold_active = 1'b1;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
                hold_active = 1'b0;
                hold_out_req = 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                if (!burst_mode) begin
                    res_ch.ready <= 1'b0;
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 4);
                    repeat (run) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : res_check
        steer_cmd_t want;
        steer_cmd_t got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.angle = res_ch.steer_angle;
            got.drive = res_ch.drive_command;
            got.rev = res_ch.reversing;
            n_cmds_seen++;
            if (got.rev === 1'b1) n_reverse++;
            if (cmd_expected.size() == 0) begin
                note_mismatch($sformatf("unexpected command angle %0d drive %0d rev %0b",
                                        got.angle, got.drive, got.rev));
            end else begin
                want = cmd_expected.pop_front();
                if (got.angle !== want.angle || got.drive !== want.drive
                        || got.rev !== want.rev)
                    note_mismatch($sformatf(
                        "angle %0d/%0d drive %0d/%0d rev %0b/%0b (expected/actual)",
                        want.angle, got.angle, want.drive, got.drive, want.rev, got.rev));
            end
        end
    end

    initial begin
        int unsigned row;
        int unsigned j;
        int unsigned len;
        int unsigned r;
        int unsigned phase;
        int unsigned phase_start;
        int unsigned rand_start;
        bit          at_end;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_FIRST_INDEX;
        i_cfg_data <= '0;
        smp_ch.valid <= 1'b0;
        smp_ch.distance <= '0;
        smp_ch.source_node <= '0;
        smp_ch.scan_last <= 1'b0;
        cur_first = FIRST_INDEX_RST;
        cur_invalid = INVALID_LIMIT_RST;
        cur_far = FAR_VALUE_RST;
        cur_turn = TURN_LIMIT_RST;
        cur_reverse = REVERSE_LIMIT_RST;
        cur_mag = STEER_MAGNITUDE_RST;
        cur_speed = DRIVE_SPEED_RST;
        cur_node = RANGE_NODE_RST;
        scan_pos = 0;
        backoff_left = 0;
        scan_ignored = 1'b0;
        for (j = 0; j < SECTORS_DEF; j++) sect_min[j] = FAR_VALUE_RST;

        // rep, distance, node, last, typed, has command, command
        scan_rows = '{
            '{1,   16'd100,   4'd2,  1'b1, 1'b1, 1'b1, '{8'sd0,   -11'sd280, 1'b0}},
            '{1,   16'hFFFF,  4'd15, 1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd0,     4'd0,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{150, 16'd1000,  4'd2,  1'b0, 1'b0, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{50,  16'd400,   4'd9,  1'b0, 1'b0, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd1000,  4'd2,  1'b1, 1'b1, 1'b1, '{8'sd30,  -11'sd280, 1'b0}},
            '{150, 16'd20,    4'd2,  1'b0, 1'b0, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd21,    4'd2,  1'b1, 1'b1, 1'b1, '{-8'sd30,  11'sd280, 1'b1}},
            '{1,   16'd5,     4'd2,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'hFFFF,  4'd7,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd0,     4'd2,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd1,     4'd0,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd20,    4'd15, 1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd21,    4'd2,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd20,    4'd2,  1'b1, 1'b1, 1'b1, '{8'sd0,   -11'sd280, 1'b0}},
            '{450, 16'd5000,  4'd2,  1'b0, 1'b0, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{50,  16'd200,   4'd6,  1'b0, 1'b0, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{525, 16'd5000,  4'd2,  1'b1, 1'b1, 1'b1, '{8'sd30,   11'sd280, 1'b1}},
            '{1,   16'd0,     4'd2,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'hFFFF,  4'd15, 1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd300,   4'd0,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd250,   4'd2,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd599,   4'd8,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}},
            '{1,   16'd600,   4'd2,  1'b1, 1'b1, 1'b0, '{8'sd0,    11'sd0,   1'b0}}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++) begin
            for (j = 0; j < scan_rows[row].rep; j++) begin
                at_end = (j == scan_rows[row].rep - 1);
                send_sample(scan_rows[row].distance, scan_rows[row].node,
                            scan_rows[row].last && at_end,
                            scan_rows[row].typed_in && at_end,
                            scan_rows[row].has_cmd, scan_rows[row].cmd);
            end
        end
        smp_ch.valid <= 1'b0;
        wait_drained();

        rand_start = n_samples;
        phase = 0;
        while ((phase < 2 || n_samples - rand_start < RANDOM_ITEMS) && phase < MAX_PHASES) begin
            burst_mode = (phase == 0) || (phase % 4 == 3);
            phase_start = n_samples;
            if (phase == 0) begin
                // output held off while short scans keep coming
                hold_out_req = 1'b1;
                wait (hold_active);
                for (j = 0; j < PRESSURE_SCANS; j++) send_scan($urandom_range(1, 4));
            end else begin
                config_random(phase == 1);
                while (n_samples - phase_start < PHASE_ITEMS) begin
                    r = $urandom_range(0, 99);
                    if (r < 80) len = $urandom_range(1, 12);
                    else if (r < 97) len = $urandom_range(150, 400);
                    else len = $urandom_range(401, 620);
                    send_scan(len);
                end
            end
            smp_ch.valid <= 1'b0;
            wait_drained();
            phase++;
        end

        $display("covered %0d samples in %0d scans over %0d random phases, %0d register writes",
                 n_samples, n_scans, phase, n_cfg_writes);
        $display("checked %0d steering commands, %0d reversing, %0d mismatches",
                 n_cmds_seen, n_reverse, n_mismatch);
        if (n_mismatch == 0 && cmd_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
